[rtl/mavg_pkg.sv]
// Shared constants for the moving average filter.
// No dependencies; imported by the top level.
package mavg_pkg;

  // Width of the window length register.
  localparam int WIN_BITS = 8;

endpackage

[rtl/mavg_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module mavg_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/moving_average_filter_unit.sv]
// Moving average filter with warm-up: top level.
// Depends on mavg_pkg and mavg_ram (history store).
//
// Each accepted sample word is written into a circular history RAM. The unit
// then reads back the newest samples_used entries, one per cycle through the
// RAM's single read port, and divides the sum with a restoring divider that
// retires one quotient bit per cycle. A new sample word is taken only once
// the result of the last one has been written into the output register.
// A finished result waits in the output register while the next sample is
// taken; only when that register still holds an unaccepted word does the
// next result wait, for as long as the stall lasts. The history needs no
// clearing after reset since only written entries are ever summed.
module moving_average_filter_unit
  import mavg_pkg::*;
#(
  parameter int HISTORY_DEPTH = 64,
  parameter int SAMPLE_BITS   = 24
) (
  input  logic clk,
  input  logic rst_n,
  // Configuration: window length.
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [WIN_BITS-1:0] cfg_data,
  // Input stream. tdata: sample.
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      in_tdata,
  // Output stream. tdata: average, then samples_used.
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((SAMPLE_BITS+$clog2(HISTORY_DEPTH+1)+7)/8)*8-1:0] out_tdata
);

  localparam int ADDR_W = $clog2(HISTORY_DEPTH);
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(HISTORY_DEPTH) + 1;
  localparam int DCNT_W = $clog2(SUM_W + 1);
  localparam int CMP_W  = ((CNT_W > WIN_BITS) ? CNT_W : WIN_BITS) + 1;
  localparam int OUT_W  = ((SAMPLE_BITS + CNT_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t                   state_r;
  logic [WIN_BITS-1:0]      window_r;
  logic [CNT_W-1:0]         fill_r;
  logic [ADDR_W-1:0]        wp_r;
  logic [ADDR_W-1:0]        rd_addr_r;
  logic [CNT_W-1:0]         issue_cnt_r;
  logic                     rd_pend_r;
  logic signed [SUM_W-1:0]  acc_r;
  logic [SUM_W-1:0]         q_r;
  logic [CNT_W-1:0]         rem_r;
  logic [DCNT_W-1:0]        dcnt_r;
  logic                     neg_r;
  logic                     out_valid_r;
  logic [SAMPLE_BITS-1:0]   avg_r;
  logic [CNT_W-1:0]         used_r;

  logic                     in_acc;
  logic                     rd_en;
  logic [SAMPLE_BITS-1:0]   rd_data;
  logic [CMP_W-1:0]         win_eff;
  logic [CMP_W-1:0]         fill_inc;
  logic [CNT_W-1:0]         fill_nxt;
  logic [SUM_W-1:0]         acc_mag;
  logic [CNT_W:0]           trial;
  logic                     trial_ge;
  logic [SAMPLE_BITS-1:0]   quot;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({used_r, avg_r});
  assign rd_en      = (state_r == ST_SUM) && (issue_cnt_r != '0);

  mavg_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (wp_r),
    .wr_data (in_tdata[SAMPLE_BITS-1:0]),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_r),
    .rd_data (rd_data)
  );

  // Effective window and the new fill count, which also drops at once when
  // the window was shrunk below it.
  always_comb begin
    if (window_r == '0) begin
      win_eff = CMP_W'(1);
    end else if (CMP_W'(window_r) > CMP_W'(HISTORY_DEPTH)) begin
      win_eff = CMP_W'(HISTORY_DEPTH);
    end else begin
      win_eff = CMP_W'(window_r);
    end
    fill_inc = CMP_W'(fill_r) + CMP_W'(1);
    if (fill_inc > win_eff) begin
      fill_nxt = CNT_W'(win_eff);
    end else begin
      fill_nxt = CNT_W'(fill_inc);
    end
  end

  // Divider datapath: magnitude of the sum, one restoring step per cycle.
  always_comb begin
    acc_mag  = acc_r[SUM_W-1] ? SUM_W'(-acc_r) : SUM_W'(acc_r);
    trial    = {rem_r, q_r[SUM_W-1]};
    trial_ge = (trial >= (CNT_W+1)'(fill_r));
    quot     = neg_r ? SAMPLE_BITS'(-q_r) : SAMPLE_BITS'(q_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      window_r    <= WIN_BITS'(1);
      fill_r      <= '0;
      wp_r        <= '0;
      issue_cnt_r <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        window_r <= cfg_data;
      end
      // In ST_DONE the output valid is handled by the state itself.
      if (out_valid_r && out_tready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            fill_r      <= fill_nxt;
            issue_cnt_r <= fill_nxt;
            rd_addr_r   <= wp_r;
            wp_r        <= (wp_r == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_r + 1'b1;
            acc_r       <= '0;
            rd_pend_r   <= 1'b0;
            state_r     <= ST_SUM;
          end
        end
        ST_SUM: begin
          // Walk back from the newest entry; read data returns in the next cycle.
          rd_pend_r <= rd_en;
          if (rd_en) begin
            issue_cnt_r <= issue_cnt_r - 1'b1;
            rd_addr_r   <= (rd_addr_r == '0) ? ADDR_W'(HISTORY_DEPTH - 1)
                                             : rd_addr_r - 1'b1;
          end
          if (rd_pend_r) begin
            acc_r <= acc_r + {{(SUM_W-SAMPLE_BITS){rd_data[SAMPLE_BITS-1]}}, rd_data};
          end
          if (!rd_en && !rd_pend_r) begin
            neg_r   <= acc_r[SUM_W-1];
            q_r     <= acc_mag;
            rem_r   <= '0;
            dcnt_r  <= DCNT_W'(SUM_W);
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (dcnt_r == '0) begin
            state_r <= ST_DONE;
          end else begin
            rem_r  <= trial_ge ? CNT_W'(trial - (CNT_W+1)'(fill_r)) : CNT_W'(trial);
            q_r    <= {q_r[SUM_W-2:0], trial_ge};
            dcnt_r <= dcnt_r - 1'b1;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            avg_r       <= quot;
            used_r      <= fill_r;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // The fill count never exceeds the history depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(HISTORY_DEPTH))
    else $error("fill count exceeds history depth");

  // After a sample word is taken, the read walk covers the new fill count.
  a_walk_len: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> (fill_r != '0) && (issue_cnt_r == fill_r))
    else $error("read walk length does not match fill count");

  // The partial remainder stays below the divisor during division.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < fill_r))
    else $error("divider remainder out of range");

  // A pending RAM read only exists during the sum walk.
  a_pend_sum: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == ST_SUM))
    else $error("history read pending outside the sum walk");

endmodule
